/* rtl/bfsa_pkg.sv */
// ----------------------------------------------------------------------------
// Best-fit slot allocator package
// Shared widths, function and status codes, and the control struct that
// steers the best-fit pick unit.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  // Default table geometry.
  localparam int SLOTS_DEF     = 16;
  localparam int ADDR_BITS_DEF = 16;

  // Fixed widths of the item fields on the channels.
  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 4;
  localparam int BASE_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;

  // Function codes of an input item.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  // Status codes of a result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_REFUSED   = 2'd3
  } status_t;

  // Control of the pick unit: restart the search, or weigh one candidate.
  typedef struct packed {
    logic clear;
    logic take;
  } bfsa_pick_ctl_t;

endpackage

/* rtl/bfsa_if.sv */
// ----------------------------------------------------------------------------
// Best-fit slot allocator channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bfsa_in_if
  import bfsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SLOT_W-1:0] slot_index;
  logic [BASE_W-1:0] slot_base;
  logic [SIZE_W-1:0] slot_size;
  logic [SIZE_W-1:0] request_size;

  modport source (output valid, func, slot_index, slot_base, slot_size, request_size,
                  input ready);
  modport sink   (input valid, func, slot_index, slot_base, slot_size, request_size,
                  output ready);
endinterface

interface bfsa_out_if
  import bfsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLOT_W-1:0] chosen_slot;
  logic [BASE_W-1:0] granted_base;
  logic [SIZE_W-1:0] remaining_size;

  modport source (output valid, status, chosen_slot, granted_base, remaining_size,
                  input ready);
  modport sink   (input valid, status, chosen_slot, granted_base, remaining_size,
                  output ready);
endinterface

/* rtl/bfsa_pick.sv */
// ----------------------------------------------------------------------------
// Best-fit pick unit
// Weighs one candidate slot per cycle while take is set and keeps the smallest size that still
// covers the request; the first candidate wins a tie.
// ----------------------------------------------------------------------------
module bfsa_pick
  import bfsa_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfsa_pick_ctl_t         ctl,
  input  logic [ADDR_BITS-1:0]   req,
  input  logic                   cand_live,
  input  logic [$clog2(SLOTS)-1:0] cand_idx,
  input  logic [ADDR_BITS-1:0]   cand_size,
  output logic                   found,
  output logic [$clog2(SLOTS)-1:0] best_idx
);

  localparam int IDX_W = $clog2(SLOTS);

  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [ADDR_BITS-1:0] best_size_r, best_size_nxt;
  logic                 fits;
  logic                 better;

  // A candidate fits when it is valid and covers the request; it replaces the
  // current best only when strictly smaller, so the lower index keeps a tie.
  assign fits   = cand_live && (cand_size >= req);
  assign better = fits && (!found_r || (cand_size < best_size_r));

  always_comb begin
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.take && better) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = cand_idx;
      best_size_nxt = cand_size;
    end
  end

  // Search registers; only the found flag needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r     <= found_nxt;
      best_idx_r  <= best_idx_nxt;
      best_size_r <= best_size_nxt;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;

endmodule

/* rtl/best_fit_slot_allocator.sv */
// ----------------------------------------------------------------------------
// Best-fit slot allocator
// Holds a table of free slots (base, size) and serves allocate items from the
// smallest valid slot that covers the request.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake     Item
//   in_ch     in    valid/ready   func, slot_index, slot_base, slot_size,
//                                 request_size
//   out_ch    out   valid/ready   status, chosen_slot, granted_base,
//                                 remaining_size
//
// A granted allocate item passes from accept through SLOTS scan reads into one
// shared size compare, then drain, fetch, write-back, result hand-off and idle
// before the next accept. A failed scan skips the write-back. Load and refused
// items go straight to the result hand-off. in_ch.ready is high only when idle; a
// result waits in the output register, and a stalled out_ch holds the next one.
// Reset is synchronous and clears the valid marks and halt flag, not the table.
//
module best_fit_slot_allocator
  import bfsa_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bfsa_in_if.sink    in_ch,
  bfsa_out_if.source out_ch
);

  localparam int               IDX_W    = $clog2(SLOTS);
  localparam int               ENTRY_W  = 2 * ADDR_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_UPDATE,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic                 halted_r, halted_nxt;
  logic [ADDR_BITS-1:0] req_r, req_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 cand_vld_r, cand_vld_nxt;
  logic                 cand_live_r, cand_live_nxt;
  logic [IDX_W-1:0]     cand_idx_r, cand_idx_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [IDX_W-1:0]     res_slot_r, res_slot_nxt;
  logic [ADDR_BITS-1:0] res_base_r, res_base_nxt;
  logic [ADDR_BITS-1:0] res_rem_r, res_rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [BASE_W-1:0]    out_base_r, out_base_nxt;
  logic [SIZE_W-1:0]    out_rem_r, out_rem_nxt;

  // Slot table: each entry is {base, size}.
  logic [ENTRY_W-1:0]   mem [SLOTS];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic [ADDR_BITS-1:0] rd_base;
  logic [ADDR_BITS-1:0] rd_size;
  logic [ADDR_BITS-1:0] new_base;
  logic [ADDR_BITS-1:0] new_size;

  bfsa_pick_ctl_t       pick_ctl;
  logic                 pick_found;
  logic [IDX_W-1:0]     pick_idx;
  logic                 accept;
  logic                 load_in_range;

  assign accept        = in_ch.valid && in_ch.ready;
  assign load_in_range = int'(in_ch.slot_index) < SLOTS;
  assign rd_base       = rd_data_r[ENTRY_W-1:ADDR_BITS];
  assign rd_size       = rd_data_r[ADDR_BITS-1:0];
  assign new_base      = rd_base + req_r;
  assign new_size      = rd_size - req_r;

  // Shared compare unit that tracks the best fitting slot during a scan.
  bfsa_pick #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .req       (req_r),
    .cand_live (cand_live_r),
    .cand_idx  (cand_idx_r),
    .cand_size (rd_size),
    .found     (pick_found),
    .best_idx  (pick_idx)
  );

  // Slot table memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    halted_nxt     = halted_r;
    req_nxt        = req_r;
    scan_idx_nxt   = scan_idx_r;
    cand_vld_nxt   = cand_vld_r;
    cand_live_nxt  = cand_live_r;
    cand_idx_nxt   = cand_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_base_nxt   = res_base_r;
    res_rem_nxt    = res_rem_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_base_nxt   = out_base_r;
    out_rem_nxt    = out_rem_r;
    rd_addr        = scan_idx_r;
    wr_en          = 1'b0;
    wr_addr        = IDX_W'(in_ch.slot_index);
    wr_data        = {ADDR_BITS'(in_ch.slot_base), ADDR_BITS'(in_ch.slot_size)};
    pick_ctl.clear = 1'b0;
    pick_ctl.take  = cand_vld_r;

    // The output register empties when the sink takes its item.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.func == FUNC_LOAD) begin
            if (load_in_range) begin
              wr_en              = 1'b1;
              valid_nxt[wr_addr] = 1'b1;
            end
            halted_nxt     = 1'b0;
            res_status_nxt = ST_LOADED;
            res_slot_nxt   = '0;
            res_base_nxt   = '0;
            res_rem_nxt    = '0;
            state_nxt      = S_RESP;
          end else if (halted_r) begin
            res_status_nxt = ST_REFUSED;
            res_slot_nxt   = '0;
            res_base_nxt   = '0;
            res_rem_nxt    = '0;
            state_nxt      = S_RESP;
          end else begin
            req_nxt        = ADDR_BITS'(in_ch.request_size);
            scan_idx_nxt   = '0;
            pick_ctl.clear = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read one entry per cycle; it reaches the pick unit in the next cycle.
        cand_vld_nxt  = 1'b1;
        cand_live_nxt = valid_r[scan_idx_r];
        cand_idx_nxt  = scan_idx_r;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        cand_vld_nxt = 1'b0;
        state_nxt    = S_FETCH;
      end
      S_FETCH: begin
        rd_addr = pick_idx;
        if (pick_found) begin
          state_nxt = S_UPDATE;
        end else begin
          halted_nxt     = 1'b1;
          res_status_nxt = ST_NO_FIT;
          res_slot_nxt   = '0;
          res_base_nxt   = '0;
          res_rem_nxt    = '0;
          state_nxt      = S_RESP;
        end
      end
      S_UPDATE: begin
        // Grant the old base and write back the shrunken slot.
        wr_en          = 1'b1;
        wr_addr        = pick_idx;
        wr_data        = {new_base, new_size};
        res_status_nxt = ST_ALLOCATED;
        res_slot_nxt   = pick_idx;
        res_base_nxt   = rd_base;
        res_rem_nxt    = new_size;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = SLOT_W'(res_slot_r);
          out_base_nxt   = BASE_W'(res_base_r);
          out_rem_nxt    = SIZE_W'(res_rem_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      halted_r    <= 1'b0;
      cand_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      halted_r     <= halted_nxt;
      req_r        <= req_nxt;
      scan_idx_r   <= scan_idx_nxt;
      cand_vld_r   <= cand_vld_nxt;
      cand_live_r  <= cand_live_nxt;
      cand_idx_r   <= cand_idx_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_base_r   <= res_base_nxt;
      res_rem_r    <= res_rem_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_base_r   <= out_base_nxt;
      out_rem_r    <= out_rem_nxt;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.chosen_slot    = out_slot_r;
  assign out_ch.granted_base   = out_base_r;
  assign out_ch.remaining_size = out_rem_r;

  // The halt flag is set only by a finished scan that found no slot.
  a_halt_after_no_fit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> ($past(state_r) == S_FETCH && !$past(pick_found)))
    else $error("halt flag set without a failed scan");

  // A write-back happens only when the scan found a slot.
  a_update_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> pick_found)
    else $error("write-back without a chosen slot");

  // The scan covers every slot before the search result is used.
  a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> ($past(scan_idx_r) == LAST_IDX))
    else $error("scan ended before the last slot");

  // A pending result moves into a free output register and releases the block.
  a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && (!out_valid_r || out_ch.ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("pending result not moved to the output register");

endmodule

/* dv/bfsa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit slot allocator checker
// Watches both channels, keeps its own copy of the slot table, and predicts
// the result of every accepted input item. Each accepted result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bfsa_checker
  import bfsa_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bfsa_in_if   in_mon,
  bfsa_out_if  out_mon,
  output int   mismatch_count,
  output int   pending_results,
  output int   load_count,
  output int   grant_count,
  output int   no_fit_count,
  output int   refusal_count
);

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [BASE_W-1:0]   base;
    logic [SIZE_W-1:0]   remaining;
  } alloc_result_t;

  // Shadow copy of the allocator state.
  logic [ADDR_BITS-1:0] slot_base_tab [SLOTS];
  logic [ADDR_BITS-1:0] slot_size_tab [SLOTS];
  logic [SLOTS-1:0]     slot_live;
  logic                 halted;

  alloc_result_t grant_queue[$];
  int            errors;
  int            n_load, n_grant, n_no_fit, n_refused;

  // Apply one input item to the shadow state and return the result it causes.
  function automatic alloc_result_t predict_allocation(
    logic [FUNC_W-1:0] func,
    logic [SLOT_W-1:0] idx,
    logic [BASE_W-1:0] base,
    logic [SIZE_W-1:0] size,
    logic [SIZE_W-1:0] req
  );
    alloc_result_t        res;
    logic [ADDR_BITS-1:0] req_w;
    int                   best;
    res   = '0;
    req_w = ADDR_BITS'(req);
    best  = -1;
    if (func == FUNC_LOAD) begin
      if (int'(idx) < SLOTS) begin
        slot_base_tab[idx] = ADDR_BITS'(base);
        slot_size_tab[idx] = ADDR_BITS'(size);
        slot_live[idx]     = 1'b1;
      end
      halted     = 1'b0;
      res.status = ST_LOADED;
    end else if (halted) begin
      res.status = ST_REFUSED;
    end else begin
      // Smallest fitting slot; the strict compare keeps the lowest index on ties.
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && slot_size_tab[i] >= req_w) begin
          if (best < 0 || slot_size_tab[i] < slot_size_tab[best]) best = i;
        end
      end
      if (best < 0) begin
        halted     = 1'b1;
        res.status = ST_NO_FIT;
      end else begin
        res.status          = ST_ALLOCATED;
        res.slot            = SLOT_W'(best);
        res.base            = BASE_W'(slot_base_tab[best]);
        slot_size_tab[best] = slot_size_tab[best] - req_w;
        slot_base_tab[best] = slot_base_tab[best] + req_w;
        res.remaining       = SIZE_W'(slot_size_tab[best]);
      end
    end
    return res;
  endfunction

  // Compare accepted results first, then record the prediction for a new item.
  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t pred;
    if (!rst_n) begin
      slot_live = '0;
      halted    = 1'b0;
      grant_queue.delete();
      errors    = 0;
      n_load    = 0;
      n_grant   = 0;
      n_no_fit  = 0;
      n_refused = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (grant_queue.size() == 0) begin
          $error("result item with no prediction waiting: status %s",
                 out_mon.status.name());
          errors++;
        end else begin
          want = grant_queue.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %s, got %0d", want.status.name(), out_mon.status);
            errors++;
          end
          if (out_mon.chosen_slot !== want.slot) begin
            $error("chosen_slot: expected %0d, got %0d", want.slot, out_mon.chosen_slot);
            errors++;
          end
          if (out_mon.granted_base !== want.base) begin
            $error("granted_base: expected 0x%04h, got 0x%04h", want.base,
                   out_mon.granted_base);
            errors++;
          end
          if (out_mon.remaining_size !== want.remaining) begin
            $error("remaining_size: expected 0x%04h, got 0x%04h", want.remaining,
                   out_mon.remaining_size);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pred = predict_allocation(in_mon.func, in_mon.slot_index, in_mon.slot_base,
                                  in_mon.slot_size, in_mon.request_size);
        grant_queue = {grant_queue, pred};
        case (pred.status)
          ST_LOADED:    n_load++;
          ST_ALLOCATED: n_grant++;
          ST_NO_FIT:    n_no_fit++;
          default:      n_refused++;
        endcase
      end
    end
    mismatch_count  <= errors;
    pending_results <= grant_queue.size();
    load_count      <= n_load;
    grant_count     <= n_grant;
    no_fit_count    <= n_no_fit;
    refusal_count   <= n_refused;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit slot allocator testbench
// Drives directed and random load and allocate items with random idle cycles
// on both channels and one long receiver stall; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import bfsa_pkg::*;

  localparam int RANDOM_ITEMS = 740;
  localparam int IDLE_LIMIT   = 3000;
  localparam int SINK_HOLD    = 300;
  localparam int DRAIN_CYCLES = SLOTS_DEF + 12;

  logic clk;
  logic rst_n;
  bit   gaps_on;
  bit   hold_request;
  int   idle_cycles;
  int   mismatch_count, pending_results;
  int   load_count, grant_count, no_fit_count, refusal_count;

  bfsa_in_if  in_bus ();
  bfsa_out_if out_bus ();

  best_fit_slot_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  bfsa_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .load_count      (load_count),
    .grant_count     (grant_count),
    .no_fit_count    (no_fit_count),
    .refusal_count   (refusal_count)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one item, with random idle cycles first; valid stays high afterward.
  task automatic send_item(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] idx,
                           logic [BASE_W-1:0] base, logic [SIZE_W-1:0] size,
                           logic [SIZE_W-1:0] req);
    while (gaps_on && $urandom_range(0, 99) < 28) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.func         <= func;
    in_bus.slot_index   <= idx;
    in_bus.slot_base    <= base;
    in_bus.slot_size    <= size;
    in_bus.request_size <= req;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Slot sizes are mostly small so that slots run dry and requests fail.
  function automatic logic [SIZE_W-1:0] pick_slot_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_request();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, 24));
    endcase
  endfunction

  // Random mix of loads and allocate requests; some bases sit near the top to wrap.
  task automatic send_random_item();
    logic [BASE_W-1:0] base;
    base = ($urandom_range(0, 4) == 0) ? BASE_W'($urandom_range(16'hFFC0, 16'hFFFF))
                                       : BASE_W'($urandom);
    if ($urandom_range(0, 99) < 30)
      send_item(FUNC_LOAD, SLOT_W'($urandom), base, pick_slot_size(), SIZE_W'($urandom));
    else
      send_item(FUNC_ALLOC, SLOT_W'($urandom), base, SIZE_W'($urandom), pick_request());
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        hold_request = 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end
      out_bus.ready <= !gaps_on || ($urandom_range(0, 99) >= 28);
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("best_fit_slot_allocator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.func         <= FUNC_LOAD;
    in_bus.slot_index   <= '0;
    in_bus.slot_base    <= '0;
    in_bus.slot_size    <= '0;
    in_bus.request_size <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table fails and halts; the next request is refused.
    send_item(FUNC_ALLOC, '0, '0, '0, 16'h0001);
    send_item(FUNC_ALLOC, '1, '1, '1, 16'h0000);
    // Equal sizes in the first and last slot: the lower index wins.
    send_item(FUNC_LOAD, 4'd15, 16'hFFF0, 16'h0020, '1);
    send_item(FUNC_LOAD, 4'd0, 16'h1000, 16'h0020, '0);
    send_item(FUNC_ALLOC, '0, '0, '0, 16'h0010);
    // Only the last slot fits; its base wraps past the top of memory.
    send_item(FUNC_ALLOC, '0, '0, '0, 16'h0020);
    // A zero request takes the smallest slot, even one of size zero.
    send_item(FUNC_ALLOC, '0, '0, '0, 16'h0000);
    send_item(FUNC_LOAD, 4'd7, 16'h0000, 16'h0000, 16'h5A5A);
    send_item(FUNC_ALLOC, '0, '0, '0, 16'h0000);
    // Full-size slot and request.
    send_item(FUNC_LOAD, 4'd3, 16'hFFFF, 16'hFFFF, '0);
    send_item(FUNC_ALLOC, '1, '1, '1, 16'hFFFF);
    send_item(FUNC_ALLOC, '0, '0, '0, 16'hFFFF);
    send_item(FUNC_ALLOC, '0, '0, '0, 16'h0001);
    // A load clears the halt flag.
    send_item(FUNC_LOAD, 4'd9, 16'hAAAA, 16'h5555, 16'hFFFF);
    send_item(FUNC_ALLOC, 4'd6, 16'h5555, 16'hAAAA, 16'h5555);
    send_item(FUNC_ALLOC, '0, '0, '0, 16'h0001);
    send_item(FUNC_LOAD, 4'd9, 16'h5555, 16'hAAAA, 16'h0000);
    send_item(FUNC_ALLOC, '0, '0, '0, 16'hAAAA);

    // Random part, with one stretch free of idling and one long receiver stall.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 250 && n < 400);
      if (n == 500) hold_request = 1'b1;
      send_random_item();
    end
    gaps_on = 1'b1;
    in_bus.valid <= 1'b0;

    // Drain outstanding results, then allow the block's latency to pass.
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d grants, %0d requests with no fit and %0d refused",
             load_count, grant_count, no_fit_count, refusal_count);
    $display("while halted, with random stalls on both channels.");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("best_fit_slot_allocator: match");
    end else begin
      $display("best_fit_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule
